@@ rtl/xeu_pkg.sv @@
`timescale 1ns / 1ps

package xeu_pkg;

  typedef enum logic {
    MODE_TEXT,
    MODE_ENTITY
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_TOO_LONG,
    ERR_EMPTY,
    ERR_EMPTY_NUM,
    ERR_BAD_DIGIT,
    ERR_UNKNOWN
  } err_t;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_QUOT    = 8'h22;

  localparam logic [7:0] TERM_RESET = CH_LT;

  localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
  localparam logic [31:0] NAME_GT   = 32'h0000_6774;
  localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
  localparam logic [31:0] NAME_APOS = 32'h6170_6F73;
  localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_t      kind;
    err_t       code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t digit_value(input logic [7:0] b, input logic hex);
    digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h30);
    end else if (hex && b >= 8'h61 && b <= 8'h66) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h57);
    end else if (hex && b >= 8'h41 && b <= 8'h46) begin
      d.ok    = 1'b1;
      d.value = 4'(b - 8'h37);
    end
    return d;
  endfunction

endpackage

@@ rtl/xeu_core.sv @@
`timescale 1ns / 1ps

module xeu_core import xeu_pkg::*; #(
  parameter int ENTITY_LIMIT = 32,
  parameter int LEN_W        = $clog2(ENTITY_LIMIT)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       take,
  input  logic [7:0] byte_in,
  output result_t    res
);

  localparam logic [LEN_W:0] LEN_MAX = (LEN_W + 1)'(ENTITY_LIMIT - 1);

  mode_t             mode_r, mode_nxt;
  logic [7:0]        term_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              numeric_r, numeric_nxt;
  logic              hex_r, hex_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic              digit_seen_r, digit_seen_nxt;
  logic              bad_r, bad_nxt;
  logic [31:0]       name_r, name_nxt;

  logic              too_long;
  digit_t            dig;
  logic [7:0]        acc_scaled;

  assign too_long   = {1'b0, len_r} >= LEN_MAX;
  assign dig        = digit_value(byte_in, hex_r);
  assign acc_scaled = hex_r ? {acc_r[3:0], 4'd0} : 8'({acc_r[4:0], 3'd0} + {acc_r[6:0], 1'b0});

  always_comb begin
    mode_nxt = mode_r;
    if (take) begin
      unique case (mode_r)
        MODE_TEXT: begin
          if (byte_in == CH_AMP) mode_nxt = MODE_ENTITY;
        end
        MODE_ENTITY: begin
          if (byte_in == CH_SEMI || too_long) mode_nxt = MODE_TEXT;
        end
        default: mode_nxt = MODE_TEXT;
      endcase
    end
  end

  always_comb begin
    len_nxt        = len_r;
    numeric_nxt    = numeric_r;
    hex_nxt        = hex_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    bad_nxt        = bad_r;
    name_nxt       = name_r;
    if (take) begin
      if (mode_r == MODE_TEXT || byte_in == CH_SEMI || too_long) begin
        if (mode_r == MODE_ENTITY || byte_in == CH_AMP) begin
          len_nxt        = '0;
          numeric_nxt    = 1'b0;
          hex_nxt        = 1'b0;
          acc_nxt        = 8'd0;
          digit_seen_nxt = 1'b0;
          bad_nxt        = 1'b0;
          name_nxt       = 32'd0;
        end
      end else begin
        len_nxt = len_r + LEN_W'(1);
        if (len_r == '0 && byte_in == CH_HASH) begin
          numeric_nxt = 1'b1;
        end else if (numeric_r) begin
          if (len_r == LEN_W'(1) && byte_in == CH_LOWER_X) begin
            hex_nxt = 1'b1;
          end else if (!dig.ok) begin
            bad_nxt = 1'b1;
          end else begin
            acc_nxt        = acc_scaled + {4'd0, dig.value};
            digit_seen_nxt = 1'b1;
          end
        end else begin
          name_nxt = {name_r[23:0], byte_in};
        end
      end
    end
  end

  always_comb begin
    res       = '0;
    res.kind  = KIND_CHAR;
    res.code  = ERR_NONE;
    unique case (mode_r)
      MODE_TEXT: begin
        if (byte_in != CH_AMP) begin
          res.valid = 1'b1;
          if (byte_in == term_r) begin
            res.kind = KIND_END;
            res.last = 1'b1;
          end else begin
            res.data = byte_in;
          end
        end
      end
      MODE_ENTITY: begin
        if (byte_in == CH_SEMI) begin
          res.valid = 1'b1;
          if (len_r == '0) begin
            res.code = ERR_EMPTY;
          end else if (numeric_r) begin
            if (bad_r) res.code = ERR_BAD_DIGIT;
            else if (!digit_seen_r) res.code = ERR_EMPTY_NUM;
            else res.data = acc_r;
          end else if (len_r == LEN_W'(2) && name_r == NAME_LT) begin
            res.data = CH_LT;
          end else if (len_r == LEN_W'(2) && name_r == NAME_GT) begin
            res.data = CH_GT;
          end else if (len_r == LEN_W'(3) && name_r == NAME_AMP) begin
            res.data = CH_AMP;
          end else if (len_r == LEN_W'(4) && name_r == NAME_APOS) begin
            res.data = CH_APOS;
          end else if (len_r == LEN_W'(4) && name_r == NAME_QUOT) begin
            res.data = CH_QUOT;
          end else begin
            res.code = ERR_UNKNOWN;
          end
        end else if (too_long) begin
          res.valid = 1'b1;
          res.code  = ERR_TOO_LONG;
        end
        if (res.code != ERR_NONE) begin
          res.kind = KIND_ERROR;
          res.last = 1'b1;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_TEXT;
      term_r       <= TERM_RESET;
      len_r        <= '0;
      numeric_r    <= 1'b0;
      hex_r        <= 1'b0;
      acc_r        <= 8'd0;
      digit_seen_r <= 1'b0;
      bad_r        <= 1'b0;
      name_r       <= 32'd0;
    end else begin
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
      numeric_r    <= numeric_nxt;
      hex_r        <= hex_nxt;
      acc_r        <= acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      bad_r        <= bad_nxt;
      name_r       <= name_nxt;
      if (cfg_wr_en) term_r <= cfg_wr_data;
    end
  end

endmodule

@@ rtl/xml_entity_unescape.sv @@
`timescale 1ns / 1ps
// XML character entity decoder, one byte of character data per item.
// Input channel: in_valid, in_stall, in_text_byte. Each accepted byte is
// registered in the input register, then decoded against the entity state.
// Result channel: out_valid, out_stall and the result fields. Plain bytes
// come out as characters and the terminator byte as an end result. A closed
// entity gives its character or an error result, and an overlong entity an
// error result; end and error results set out_last. The '&' byte and the
// other bytes of an entity body give no result. An accepted byte passes the
// input register, then the result register. Throughput is one item per cycle
// while the receiver does not stall, set by the single decode stage between them.
// When the receiver stalls with a result held, the decode stage waits and
// in_stall rises once the input register is also occupied.
// The terminator register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle (the block does not enforce this). Synchronous
// reset clears both stages, returns to text mode and sets the terminator to '<'.
module xml_entity_unescape import xeu_pkg::*; #(
  parameter int ENTITY_LIMIT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_decoded_byte,
  output logic [1:0] out_result_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic [2:0] out_code_r;
  logic       out_last_r;
  logic       out_free;
  logic       fire;
  logic       in_take;
  result_t    res;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (fire) s1_valid_nxt = 1'b0;
  end

  xeu_core #(
    .ENTITY_LIMIT(ENTITY_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .take       (fire),
    .byte_in    (s1_byte_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (fire && res.valid) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_text_byte;
    if (fire && res.valid) begin
      out_byte_r <= res.data;
      out_kind_r <= res.kind;
      out_code_r <= res.code;
      out_last_r <= res.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_decoded_byte = out_byte_r;
  assign out_result_kind  = out_kind_r;
  assign out_error_code   = out_code_r;
  assign out_last         = out_last_r;

  a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_result_kind != KIND_CHAR)))
    else $error("last flag disagrees with result kind");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_error_code != ERR_NONE) == (out_result_kind == KIND_ERROR)))
    else $error("error code disagrees with result kind");

  a_zero_byte_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != KIND_CHAR) |-> (out_decoded_byte == 8'd0))
    else $error("end or error result carries a non-zero byte");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a waiting item");

endmodule
